// ===== sv/s7c_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and constant functions for the seconds-to-seven-segment
// countdown readout. No dependencies; used by every module of the block.
package s7c_pkg;

    // Field and lane widths
    localparam int SEC_W       = 40;   // signed seconds input
    localparam int REM_W       = 39;   // magnitude of a non-negative count
    localparam int DAYQ_W      = 23;   // days quotient, 2^39 / 86400 < 2^23
    localparam int DIGIT_LIMIT = 6;    // most day digits any build can show
    localparam int XQ_W        = 4 * DIGIT_LIMIT;  // day quotient / BCD lane
    localparam int TR_W        = 17;   // seconds within a day
    localparam int TQ_W        = 16;   // packed time digit bits
    localparam int SEG_W       = 7;
    localparam int HMS_W       = 2 * SEG_W;
    localparam int CNT_W       = 3;    // day cell count register

    localparam int DIV_STAGES  = DAYQ_W;  // one quotient bit per cell
    localparam int TIME_STAGES = TQ_W;

    localparam longint SECS_PER_DAY = 86400;

    // Subtrahends of the time-of-day lane, most significant bit first:
    // hour tens (2 bits), hour units (4), minute tens (3), minute units (4),
    // second tens (3). What is left is the seconds units digit.
    localparam logic [TR_W-1:0] TIME_SUB [TIME_STAGES] = '{
        17'd72000, 17'd36000,
        17'd28800, 17'd14400, 17'd7200, 17'd3600,
        17'd2400,  17'd1200,  17'd600,
        17'd480,   17'd240,   17'd120,  17'd60,
        17'd40,    17'd20,    17'd10
    };

    localparam logic [19:0] POW10 [DIGIT_LIMIT] = '{
        20'd1, 20'd10, 20'd100, 20'd1000, 20'd10000, 20'd100000
    };

    // Largest day value per cell count (entries 0 and 7 never used)
    localparam logic [DAYQ_W-1:0] DAY_MAX [8] = '{
        23'd0, 23'd9, 23'd99, 23'd999, 23'd9999, 23'd99999, 23'd999999,
        23'd999999
    };

    // One item as it moves down the row of cells
    typedef struct packed {
        logic [REM_W-1:0] x_rem;   // dividend, later days being split to BCD
        logic [XQ_W-1:0]  x_quo;   // days quotient, later day BCD digits
        logic [TR_W-1:0]  t_rem;   // seconds within the day being split
        logic [TQ_W-1:0]  t_quo;   // time digit bits
        logic             clamped;
    } s7c_item_t;

    // Subtrahend of division cell k: 86400 shifted to quotient bit 22-k
    function automatic logic [REM_W-1:0] s7c_div_sub(input int k);
        longint v;
        v = SECS_PER_DAY << (DIV_STAGES - 1 - k);
        return REM_W'(v);
    endfunction

    // Subtrahend of BCD cell j: weight 8,4,2,1 of digit (digits-1-j/4)
    function automatic logic [REM_W-1:0] s7c_bcd_sub(input int j, input int digits);
        longint w;
        longint p;
        w = 0;
        p = 0;
        if (j < 4 * digits) begin
            w = longint'(8 >> (j % 4));
            p = longint'(POW10[digits - 1 - j / 4]);
        end
        return REM_W'(w * p);
    endfunction

    function automatic logic [TR_W-1:0] s7c_time_sub(input int j);
        logic [TR_W-1:0] v;
        v = '0;
        if (j < TIME_STAGES) begin
            v = TIME_SUB[j];
        end
        return v;
    endfunction

    // Register write value: 0 stores 1, 7 stores 6, then capped at the build limit
    function automatic logic [CNT_W-1:0] s7c_clamp_cells(input logic [CNT_W-1:0] v,
                                                         input int maxc);
        logic [CNT_W-1:0] c;
        c = v;
        if (c < 3'd1) begin
            c = 3'd1;
        end
        if (c > 3'd6) begin
            c = 3'd6;
        end
        if (c > CNT_W'(maxc)) begin
            c = CNT_W'(maxc);
        end
        return c;
    endfunction

    // Segment a in bit 0 through g in bit 6
    function automatic logic [SEG_W-1:0] s7c_seg(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

// ===== sv/s7c_cell.sv =====
`timescale 1ns / 1ps
// One restoring-subtract cell of the conversion row: each lane compares against a
// fixed subtrahend, subtracts if it fits and shifts the result bit in. Uses s7c_pkg.
module s7c_cell #(
    parameter logic [38:0] X_SUB = '0,   // zero: lane passes through
    parameter logic [16:0] T_SUB = '0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  s7c_pkg::s7c_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output s7c_pkg::s7c_item_t  out_item
);
    import s7c_pkg::*;

    logic      valid_reg;
    s7c_item_t item_reg;
    s7c_item_t item_next;
    logic      x_ge;
    logic      t_ge;

    assign in_ready  = ~valid_reg | out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Compare, subtract, shift in the quotient bit
    always_comb begin
        item_next = in_item;
        x_ge      = in_item.x_rem >= X_SUB;
        t_ge      = in_item.t_rem >= T_SUB;
        if (X_SUB != '0) begin
            if (x_ge) begin
                item_next.x_rem = in_item.x_rem - X_SUB;
            end
            item_next.x_quo = {in_item.x_quo[XQ_W-2:0], x_ge};
        end
        if (T_SUB != '0) begin
            if (t_ge) begin
                item_next.t_rem = in_item.t_rem - T_SUB;
            end
            item_next.t_quo = {in_item.t_quo[TQ_W-2:0], t_ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== sv/s7c_clamp.sv =====
`timescale 1ns / 1ps
// Day saturation stage between the day division and the digit split: clamps days
// to 10^cells-1 and hands the within-day seconds to the time lane. Uses s7c_pkg.
module s7c_clamp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [s7c_pkg::CNT_W-1:0]     day_count,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  s7c_pkg::s7c_item_t            in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output s7c_pkg::s7c_item_t            out_item
);
    import s7c_pkg::*;

    logic              valid_reg;
    s7c_item_t         item_reg;
    s7c_item_t         item_next;
    logic [DAYQ_W-1:0] days;
    logic [DAYQ_W-1:0] day_max;
    logic              over;

    assign in_ready  = ~valid_reg | out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Saturate days; remainder of the day division seeds the time lane
    always_comb begin
        days    = in_item.x_quo[DAYQ_W-1:0];
        day_max = DAY_MAX[day_count];
        over    = days > day_max;
        item_next.x_rem   = REM_W'(over ? day_max : days);
        item_next.x_quo   = '0;
        item_next.t_rem   = in_item.x_rem[TR_W-1:0];
        item_next.t_quo   = '0;
        item_next.clamped = over;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== sv/s7c_encode.sv =====
`timescale 1ns / 1ps
// Output register of the readout: maps each decimal digit to its segment
// pattern and blanks day cells above the configured count. Uses s7c_pkg.
module s7c_encode #(
    parameter int MAX_DAY_CELLS = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [s7c_pkg::CNT_W-1:0]         day_count,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  s7c_pkg::s7c_item_t                in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [7*MAX_DAY_CELLS-1:0]        day_segments,
    output logic [s7c_pkg::HMS_W-1:0]         hour_segments,
    output logic [s7c_pkg::HMS_W-1:0]         minute_segments,
    output logic [s7c_pkg::HMS_W-1:0]         second_segments,
    output logic                              days_clamped
);
    import s7c_pkg::*;

    localparam int DAY_W = SEG_W * MAX_DAY_CELLS;

    logic             valid_reg;
    logic [DAY_W-1:0] day_reg;
    logic [DAY_W-1:0] day_next;
    logic [HMS_W-1:0] hour_reg;
    logic [HMS_W-1:0] hour_next;
    logic [HMS_W-1:0] minute_reg;
    logic [HMS_W-1:0] minute_next;
    logic [HMS_W-1:0] second_reg;
    logic [HMS_W-1:0] second_next;
    logic             clamped_reg;

    assign in_ready        = ~valid_reg | out_ready;
    assign out_valid       = valid_reg;
    assign day_segments    = day_reg;
    assign hour_segments   = hour_reg;
    assign minute_segments = minute_reg;
    assign second_segments = second_reg;
    assign days_clamped    = clamped_reg;

    // Day cells: BCD digit i sits in x_quo[4i+3:4i]; cells past day_count blank
    always_comb begin
        for (int i = 0; i < MAX_DAY_CELLS; i++) begin
            day_next[SEG_W*i +: SEG_W] = (CNT_W'(i) < day_count)
                ? s7c_seg(in_item.x_quo[4*i +: 4]) : '0;
        end
    end

    // Time digits: packed quotient bits, seconds units is the final remainder
    always_comb begin
        hour_next   = {s7c_seg({2'b00, in_item.t_quo[15:14]}),
                       s7c_seg(in_item.t_quo[13:10])};
        minute_next = {s7c_seg({1'b0, in_item.t_quo[9:7]}),
                       s7c_seg(in_item.t_quo[6:3])};
        second_next = {s7c_seg({1'b0, in_item.t_quo[2:0]}),
                       s7c_seg(in_item.t_rem[3:0])};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            day_reg     <= day_next;
            hour_reg    <= hour_next;
            minute_reg  <= minute_next;
            second_reg  <= second_next;
            clamped_reg <= in_item.clamped;
        end
    end

endmodule

// ===== sv/seconds_to_seven_segment_countdown.sv =====
`timescale 1ns / 1ps
// Seconds-to-seven-segment countdown readout, top level. Uses s7c_pkg, s7c_cell,
// s7c_clamp and s7c_encode.
//
// Converts a signed seconds count (negative reads as zero) into "ddd hh:mm:ss"
// seven-segment patterns, segment a in bit 0. The block is a row of registered
// subtract cells: 23 cells produce the day quotient one bit each, one cell
// saturates days at 10^day_count-1 (days_clamped flags it), then
// max(4*MAX_DAY_CELLS, 16) cells split days and the time of day into decimal
// digits, and a final register encodes the segments. It takes one transfer per cycle
// unless m_ready holds the output back. Each stage holds its item while the next
// one is full, so bubbles still fill while a result waits at the output.
// Register 0 (byte address 0) is day_count, values 1..MAX_DAY_CELLS, reset min(3, MAX_DAY_CELLS);
// write it only while the block is empty.
module seconds_to_seven_segment_countdown #(
    parameter int MAX_DAY_CELLS = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // seconds in
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [s7c_pkg::SEC_W-1:0]  s_seconds_in,
    // segments out
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [7*MAX_DAY_CELLS-1:0]        m_day_segments,
    output logic [s7c_pkg::HMS_W-1:0]         m_hour_segments,
    output logic [s7c_pkg::HMS_W-1:0]         m_minute_segments,
    output logic [s7c_pkg::HMS_W-1:0]         m_second_segments,
    output logic                              m_days_clamped
);
    import s7c_pkg::*;

    localparam int BCD_STAGES = 4 * MAX_DAY_CELLS;
    localparam int SPLIT_STAGES = (BCD_STAGES > TIME_STAGES) ? BCD_STAGES : TIME_STAGES;
    localparam int CLAMP_IDX = DIV_STAGES;
    localparam int LAST_IDX = DIV_STAGES + 1 + SPLIT_STAGES;

    localparam logic REG_DAY_COUNT = 1'b0;   // register index from paddr[2]

    logic [CNT_W-1:0] day_count_reg;
    logic             cfg_write;

    s7c_item_t stage_item  [LAST_IDX+1];
    logic      stage_valid [LAST_IDX+1];
    logic      stage_ready [LAST_IDX+1];

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_DAY_COUNT);
    assign prdata    = (paddr[2] == REG_DAY_COUNT) ? {29'd0, day_count_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            day_count_reg <= s7c_clamp_cells(3'd3, MAX_DAY_CELLS);
        end else if (cfg_write) begin
            day_count_reg <= s7c_clamp_cells(pwdata[CNT_W-1:0], MAX_DAY_CELLS);
        end
    end

    // Input transfer: negative counts enter as zero
    always_comb begin
        stage_item[0].x_rem   = s_seconds_in[SEC_W-1] ? '0 : s_seconds_in[REM_W-1:0];
        stage_item[0].x_quo   = '0;
        stage_item[0].t_rem   = '0;
        stage_item[0].t_quo   = '0;
        stage_item[0].clamped = 1'b0;
    end
    assign stage_valid[0] = s_valid;
    assign s_ready        = stage_ready[0];

    // Day division: one quotient bit per cell
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        s7c_cell #(
            .X_SUB (s7c_div_sub(k)),
            .T_SUB ('0)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[k]),
            .in_ready  (stage_ready[k]),
            .in_item   (stage_item[k]),
            .out_valid (stage_valid[k+1]),
            .out_ready (stage_ready[k+1]),
            .out_item  (stage_item[k+1])
        );
    end

    // Day saturation
    s7c_clamp u_clamp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .day_count (day_count_reg),
        .in_valid  (stage_valid[CLAMP_IDX]),
        .in_ready  (stage_ready[CLAMP_IDX]),
        .in_item   (stage_item[CLAMP_IDX]),
        .out_valid (stage_valid[CLAMP_IDX+1]),
        .out_ready (stage_ready[CLAMP_IDX+1]),
        .out_item  (stage_item[CLAMP_IDX+1])
    );

    // Digit split: day BCD lane and time-of-day lane side by side
    for (genvar j = 0; j < SPLIT_STAGES; j++) begin : g_split
        s7c_cell #(
            .X_SUB (s7c_bcd_sub(j, MAX_DAY_CELLS)),
            .T_SUB (s7c_time_sub(j))
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[CLAMP_IDX+1+j]),
            .in_ready  (stage_ready[CLAMP_IDX+1+j]),
            .in_item   (stage_item[CLAMP_IDX+1+j]),
            .out_valid (stage_valid[CLAMP_IDX+2+j]),
            .out_ready (stage_ready[CLAMP_IDX+2+j]),
            .out_item  (stage_item[CLAMP_IDX+2+j])
        );
    end

    // Segment encode and output register
    s7c_encode #(
        .MAX_DAY_CELLS (MAX_DAY_CELLS)
    ) u_encode (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .day_count       (day_count_reg),
        .in_valid        (stage_valid[LAST_IDX]),
        .in_ready        (stage_ready[LAST_IDX]),
        .in_item         (stage_item[LAST_IDX]),
        .out_valid       (m_valid),
        .out_ready       (m_ready),
        .day_segments    (m_day_segments),
        .hour_segments   (m_hour_segments),
        .minute_segments (m_minute_segments),
        .second_segments (m_second_segments),
        .days_clamped    (m_days_clamped)
    );

endmodule
